[design/aes_pkg.sv]
// Shared AES constants and byte-level functions: S-box tables built at
// elaboration, GF(2^8) helpers, round transforms. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

    localparam int NB_WORDS = 60;
    localparam int NSTG     = 15;

    typedef enum logic [2:0] {
        CFG_KEY_SIZE = 3'd0,
        CFG_KEY_W0   = 3'd1,
        CFG_KEY_W1   = 3'd2,
        CFG_KEY_W2   = 3'd3,
        CFG_KEY_W3   = 3'd4
    } t_cfg_idx;

    typedef logic [127:0] t_block;

    function automatic logic [7:0] f_dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] f_gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] aa;
        p  = 8'h00;
        aa = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ aa;
            aa = f_dbl(aa);
        end
        return p;
    endfunction

    function automatic logic [7:0] f_ginv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] base;
        logic [7:0] e;
        r    = 8'h01;
        base = x;
        e    = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) r = f_gmul(r, base);
            base = f_gmul(base, base);
        end
        return r;
    endfunction

    function automatic logic [7:0] f_rotl(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [2047:0] f_gen_sbox(input logic inv);
        logic [2047:0] t;
        logic [7:0]    b;
        logic [7:0]    y;
        t = '0;
        for (int x = 0; x < 256; x++) begin
            if (!inv) begin
                b = f_ginv(x[7:0]);
                y = b ^ f_rotl(b, 1) ^ f_rotl(b, 2) ^ f_rotl(b, 3) ^ f_rotl(b, 4) ^ 8'h63;
            end else begin
                b = f_rotl(x[7:0], 1) ^ f_rotl(x[7:0], 3) ^ f_rotl(x[7:0], 6) ^ 8'h05;
                y = f_ginv(b);
            end
            t[x*8 +: 8] = y;
        end
        return t;
    endfunction

    localparam logic [2047:0] SBOX_FWD = f_gen_sbox(1'b0);
    localparam logic [2047:0] SBOX_INV = f_gen_sbox(1'b1);

    function automatic logic [7:0] f_sbox(input logic [7:0] x);
        return SBOX_FWD[{x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] f_isbox(input logic [7:0] x);
        return SBOX_INV[{x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] f_rcon(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1B;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // byte k of a block sits at bits 127-8k downward; row r of column c is byte 4c+r
    function automatic t_block f_sub(input t_block s, input logic inv);
        t_block o;
        for (int k = 0; k < 16; k++)
            o[127-8*k -: 8] = inv ? f_isbox(s[127-8*k -: 8]) : f_sbox(s[127-8*k -: 8]);
        return o;
    endfunction

    function automatic t_block f_shift(input t_block s, input logic inv);
        t_block o;
        int     src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
                o[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
            end
        return o;
    endfunction

    function automatic t_block f_mix(input t_block s, input logic inv);
        t_block     o;
        logic [7:0] m [4];
        logic [7:0] acc;
        if (inv) begin
            m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
        end else begin
            m[0] = 8'd2;  m[1] = 8'd3;  m[2] = 8'd1;  m[3] = 8'd1;
        end
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc = acc ^ f_gmul(m[(k + 4 - r) % 4], s[127-8*(4*c+k) -: 8]);
                o[127-8*(4*c+r) -: 8] = acc;
            end
        return o;
    endfunction

endpackage
`default_nettype wire

[design/aes_in_if.sv]
// Input channel: valid/ready with one block and the encrypt/decrypt select.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] block_upper;
    logic [63:0] block_lower;
    modport source (output valid, kind, block_upper, block_lower, input ready);
    modport sink   (input valid, kind, block_upper, block_lower, output ready);
endinterface
`default_nettype wire

[design/aes_out_if.sv]
// Output channel: valid/ready with one result block.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_upper;
    logic [63:0] result_lower;
    modport source (output valid, result_upper, result_lower, input ready);
    modport sink   (input valid, result_upper, result_lower, output ready);
endinterface
`default_nettype wire

[design/aes_block_cipher_core.sv]
// AES-128/192/256 block cipher, one round per pipeline stage, plus key schedule sequencer.
// Depends on aes_pkg, aes_in_if, aes_out_if.
//
//   channel   dir  payload                          transaction
//   i_blk     in   kind, block_upper, block_lower   valid & ready
//   o_res     out  result_upper, result_lower       valid & ready
//   i_cfg_*   in   idx, data                        i_cfg_we
//
// Initial key add + 14 round stages, all registered (short keys pass through the
// tail stages). One block per cycle while the output is not stalled.
// After reset or any config write the key schedule runs one word per cycle;
// i_blk.ready is low meanwhile.
// A stalled output freezes the whole pipeline; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
module aes_block_cipher_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    aes_in_if.sink           i_blk,
    aes_out_if.source        o_res
);
    import aes_pkg::*;

    logic [1:0]  r_key_size;
    logic [63:0] r_key [4];
    logic        r_kload;
    logic        r_krun;
    logic [5:0]  r_ki;
    logic [2:0]  r_kmod;
    logic [3:0]  r_krc;
    logic [31:0] r_win [8];
    logic [31:0] r_rk [NB_WORDS];

    logic [3:0]  nk;
    logic [5:0]  kend;
    logic [31:0] t_rot;
    logic [31:0] t_sub;
    logic [31:0] n_word;
    logic        k_rot;
    logic        k_sub;
    logic        busy;

    always_comb begin
        if (r_key_size[1]) begin
            nk = 4'd8; kend = 6'd60;
        end else if (r_key_size[0]) begin
            nk = 4'd6; kend = 6'd52;
        end else begin
            nk = 4'd4; kend = 6'd44;
        end
    end

    assign busy  = r_kload || r_krun;
    assign k_rot = (r_kmod == 3'd0);
    assign k_sub = k_rot || (r_key_size[1] && r_kmod == 3'd4);
    assign t_rot = k_rot ? {r_win[0][23:0], r_win[0][31:24]} : r_win[0];
    assign t_sub = k_sub ? {f_sbox(t_rot[31:24]), f_sbox(t_rot[23:16]),
                            f_sbox(t_rot[15:8]), f_sbox(t_rot[7:0])} : t_rot;
    assign n_word = r_win[nk[2:0] - 3'd1] ^ t_sub ^ (k_rot ? {f_rcon(r_krc), 24'h0} : 32'h0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= 2'd0;
            for (int j = 0; j < 4; j++) r_key[j] <= 64'h0;
            r_kload <= 1'b1;
            r_krun  <= 1'b0;
            r_ki    <= 6'd0;
            r_kmod  <= 3'd0;
            r_krc   <= 4'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_KEY_SIZE) r_key_size <= i_cfg_data[1:0];
            else if (i_cfg_idx == CFG_KEY_W0) r_key[0] <= i_cfg_data;
            else if (i_cfg_idx == CFG_KEY_W1) r_key[1] <= i_cfg_data;
            else if (i_cfg_idx == CFG_KEY_W2) r_key[2] <= i_cfg_data;
            else if (i_cfg_idx == CFG_KEY_W3) r_key[3] <= i_cfg_data;
            r_kload <= 1'b1;
            r_krun  <= 1'b0;
        end else if (r_kload) begin
            r_kload <= 1'b0;
            r_krun  <= 1'b1;
            r_ki    <= {2'b00, nk};
            r_kmod  <= 3'd0;
            r_krc   <= 4'd0;
        end else if (r_krun) begin
            r_ki   <= r_ki + 6'd1;
            r_kmod <= (r_kmod == nk[2:0] - 3'd1) ? 3'd0 : r_kmod + 3'd1;
            if (k_rot) r_krc <= r_krc + 4'd1;
            if (r_ki == kend - 6'd1) r_krun <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_kload) begin
            for (int j = 0; j < 8; j++) begin
                r_rk[j] <= r_key[j/2][63-32*(j%2) -: 32];
                if (j < nk) r_win[j] <= r_key[(nk-1-j)/2][63-32*((nk-1-j)%2) -: 32];
                else r_win[j] <= 32'h0;
            end
        end else if (r_krun) begin
            r_rk[r_ki] <= n_word;
            r_win[0]   <= n_word;
            for (int j = 1; j < 8; j++) r_win[j] <= r_win[j-1];
        end
    end

    t_block rk [NSTG];
    for (genvar k = 0; k < NSTG; k++) begin : g_rk
        assign rk[k] = {r_rk[4*k], r_rk[4*k+1], r_rk[4*k+2], r_rk[4*k+3]};
    end

    logic   r_v  [NSTG];
    logic   r_kd [NSTG];
    t_block r_st [NSTG];
    t_block n_st [NSTG];
    logic   en;
    logic   acc;

    assign en          = !r_v[NSTG-1] || o_res.ready;
    assign i_blk.ready = en && !busy;
    assign acc         = i_blk.valid && i_blk.ready;

    always_comb begin
        t_block k0;
        if (!i_blk.kind) k0 = rk[0];
        else if (r_key_size[1]) k0 = rk[14];
        else if (r_key_size[0]) k0 = rk[12];
        else k0 = rk[10];
        n_st[0] = {i_blk.block_upper, i_blk.block_lower} ^ k0;
    end

    for (genvar j = 1; j < NSTG; j++) begin : g_rnd
        localparam int D10 = (10 - j < 0) ? 0 : 10 - j;
        localparam int D12 = (12 - j < 0) ? 0 : 12 - j;
        localparam int D14 = 14 - j;
        logic [3:0] nr;
        t_block     kk;
        t_block     es;
        t_block     ds;
        always_comb begin
            nr = r_key_size[1] ? 4'd14 : (r_key_size[0] ? 4'd12 : 4'd10);
            if (!r_kd[j-1]) kk = rk[j];
            else if (r_key_size[1]) kk = rk[D14];
            else if (r_key_size[0]) kk = rk[D12];
            else kk = rk[D10];
            es = f_shift(f_sub(r_st[j-1], 1'b0), 1'b0);
            ds = f_sub(f_shift(r_st[j-1], 1'b1), 1'b1) ^ kk;
            priority if (4'(j) > nr) begin
                n_st[j] = r_st[j-1];
            end else if (4'(j) == nr) begin
                n_st[j] = r_kd[j-1] ? ds : es ^ kk;
            end else begin
                n_st[j] = r_kd[j-1] ? f_mix(ds, 1'b1) : f_mix(es, 1'b0) ^ kk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NSTG; j++) r_v[j] <= 1'b0;
        end else if (en) begin
            r_v[0] <= acc;
            for (int j = 1; j < NSTG; j++) r_v[j] <= r_v[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= n_st[0];
            r_kd[0] <= i_blk.kind;
            for (int j = 1; j < NSTG; j++) begin
                r_st[j] <= n_st[j];
                r_kd[j] <= r_kd[j-1];
            end
        end
    end

    assign o_res.valid        = r_v[NSTG-1];
    assign o_res.result_upper = r_st[NSTG-1][127:64];
    assign o_res.result_lower = r_st[NSTG-1][63:0];

    a_ki_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_krun |-> r_ki < kend) else $error("key index past schedule end");
    a_acc_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_v[0]) else $error("accepted block missing in first stage");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r_v[NSTG-1] && $stable(r_st[NSTG-1])) else $error("result lost in stall");
    a_no_sched_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_krun |-> !r_v[0] || $past(r_v[0])) else $error("block entered during key schedule");

endmodule
`default_nettype wire
